FILE: src/stfr_pkg.sv
// Shared constants, command codes and the 5x8 font for the text framebuffer renderer.
// Used by stfr_mask, the top level and the testbench; depends on nothing.
package stfr_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_SIZE    = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(STORE_SIZE);
    localparam int PAGE_W        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int GLYPH_COLS    = 5;
    localparam int GLYPH_ROWS    = 8;
    localparam int CELL_STEP     = 6;

    localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGE_COUNT - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_SIZE - 1);
    localparam logic [2:0]        COL_LAST  = 3'(GLYPH_COLS - 1);
    localparam logic [2:0]        SCALE_RESET = 3'd2;

    localparam logic [1:0] CMD_SET_CURSOR = 2'd0;
    localparam logic [1:0] CMD_DRAW_CHAR  = 2'd1;
    localparam logic [1:0] CMD_CLEAR      = 2'd2;
    localparam logic [1:0] CMD_READ_BYTE  = 2'd3;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [PAGE_W-1:0] page_t;

    // Column col of the glyph for code; column 0 sits in the low byte of the row.
    function automatic logic [7:0] glyph_column(input logic [7:0] code, input logic [2:0] col);
        logic [39:0] g;
        logic [7:0]  res;
        case (code)
            8'd46:   g = {8'h00, 8'h00, 8'h60, 8'h60, 8'h00};
            8'd58:   g = {8'h00, 8'h00, 8'h36, 8'h36, 8'h00};
            8'd48:   g = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
            8'd49:   g = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
            8'd50:   g = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
            8'd51:   g = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
            8'd52:   g = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
            8'd53:   g = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
            8'd54:   g = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
            8'd55:   g = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
            8'd56:   g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            8'd57:   g = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
            8'd65:   g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
            8'd68:   g = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
            8'd76:   g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
            8'd82:   g = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
            8'd83:   g = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
            8'd84:   g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
            8'd86:   g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
            default: g = 40'h0;
        endcase
        case (col)
            3'd0:    res = g[7:0];
            3'd1:    res = g[15:8];
            3'd2:    res = g[23:16];
            3'd3:    res = g[31:24];
            3'd4:    res = g[39:32];
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

FILE: src/stfr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; holds the framebuffer bytes.
module stfr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/stfr_mask.sv
// Pixel unit: the set of lit bits of one store byte for one scaled glyph column.
// Depends on stfr_pkg for the page geometry.
module stfr_mask
    import stfr_pkg::*;
(
    input  page_t      page,
    input  logic [7:0] row,
    input  logic [2:0] scale,
    input  logic [7:0] colbits,
    output logic [7:0] mask
);

    localparam int Y_W = PAGE_W + 3;

    logic [5:0]     span;
    logic [5:0]     thr [7];
    logic [Y_W-1:0] y   [8];
    logic [7:0]     d   [8];
    logic [2:0]     r   [8];

    always_comb
    begin
        span = 6'(scale) * 6'(GLYPH_ROWS);
        for (int k = 0; k < 7; k++)
        begin
            thr[k] = 6'(scale) * 6'(k + 1);
        end
        for (int n = 0; n < 8; n++)
        begin
            y[n] = {page, 3'(n)};
            d[n] = 8'(y[n]) - row;
            r[n] = 3'd0;
            for (int k = 0; k < 7; k++)
            begin
                r[n] = r[n] + 3'(d[n] >= 8'(thr[k]));
            end
            mask[n] = (32'(y[n]) < SCREEN_HEIGHT) && (d[n] < 8'(span)) && colbits[r[n]];
        end
    end

endmodule

FILE: src/scaled_text_framebuffer_renderer.sv
// Top level: stream ports, command sequencer, cursor state and result register.
// Uses stfr_pkg, stfr_ram and stfr_mask.
// A draw walks the 5*scale scaled columns of the glyph and skips blank or clipped ones;
// for each visible one it steps through all pages; each lit byte is read, then written.
// A clear writes zero to every store byte in turn.
// One item at a time; reset clears cursor and halt, then zeroes the store.
module scaled_text_framebuffer_renderer
    import stfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,       // text_scale
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,    // pos_x, pos_y, character, string_start, byte_index
    input  logic [1:0]  s_axis_tuser,    // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata     // read_data, cursor_col, string_halted
);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CLEAR = 4'd2;
    localparam logic [3:0] S_RDATA = 4'd3;
    localparam logic [3:0] S_COL   = 4'd4;
    localparam logic [3:0] S_PRD   = 4'd5;
    localparam logic [3:0] S_PWR   = 4'd6;
    localparam logic [3:0] S_ADV   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [7:0] in_pos_x;
    logic [7:0] in_pos_y;
    logic [7:0] in_char;
    logic       in_start;
    logic [9:0] in_bidx;

    assign in_pos_x = s_axis_tdata[7:0];
    assign in_pos_y = s_axis_tdata[15:8];
    assign in_char  = s_axis_tdata[23:16];
    assign in_start = s_axis_tdata[24];
    assign in_bidx  = s_axis_tdata[34:25];

    logic [3:0]  state_reg, state_next;
    addr_t       clr_cnt_reg, clr_cnt_next;
    logic [2:0]  c_reg, c_next;
    logic [2:0]  dx_reg, dx_next;
    logic [7:0]  px_reg, px_next;
    page_t       page_reg, page_next;
    logic [7:0]  colbits_reg, colbits_next;
    logic [7:0]  mask_reg, mask_next;
    addr_t       addr_reg, addr_next;
    logic [7:0]  code_reg, code_next;
    logic        in_range_reg, in_range_next;
    logic [7:0]  cursor_col_reg, cursor_col_next;
    logic [7:0]  cursor_row_reg, cursor_row_next;
    logic        halt_reg, halt_next;
    logic [2:0]  scale_reg;
    logic [7:0]  rdata_reg, rdata_next;
    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg, out_data_next;

    logic        accept;
    logic        halt_eff;
    logic        do_step;
    logic        do_page;
    logic [7:0]  glyph_bits;
    logic [7:0]  unit_mask;
    logic [5:0]  adv_step;
    logic [7:0]  adv_col;
    addr_t       page_addr;
    logic        ram_we;
    addr_t       ram_waddr;
    logic [7:0]  ram_wdata;
    addr_t       ram_raddr;
    logic [7:0]  ram_rdata;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign glyph_bits = glyph_column(code_reg, c_reg);
    assign page_addr  = ADDR_W'(page_reg) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(px_reg);
    assign adv_step   = 6'(scale_reg) * 6'(CELL_STEP);
    assign adv_col    = cursor_col_reg + 8'(adv_step);
    assign halt_eff   = in_start ? 1'b0 : halt_reg;

    stfr_mask u_mask (
        .page    (page_reg),
        .row     (cursor_row_reg),
        .scale   (scale_reg),
        .colbits (colbits_reg),
        .mask    (unit_mask)
    );

    assign ram_we    = (state_reg == S_INIT) || (state_reg == S_CLEAR) || (state_reg == S_PWR);
    assign ram_waddr = (state_reg == S_PWR) ? addr_reg : clr_cnt_reg;
    assign ram_wdata = (state_reg == S_PWR) ? (ram_rdata | mask_reg) : 8'h00;
    assign ram_raddr = (state_reg == S_IDLE) ? ADDR_W'(in_bidx) : page_addr;

    stfr_ram #(
        .DATA_W (8),
        .DEPTH  (STORE_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        c_next          = c_reg;
        dx_next         = dx_reg;
        px_next         = px_reg;
        page_next       = page_reg;
        colbits_next    = colbits_reg;
        mask_next       = mask_reg;
        addr_next       = addr_reg;
        code_next       = code_reg;
        in_range_next   = in_range_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        halt_next       = halt_reg;
        rdata_next      = rdata_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        do_step         = 1'b0;
        do_page         = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    rdata_next = 8'h00;
                    case (s_axis_tuser)
                        CMD_SET_CURSOR:
                        begin
                            cursor_col_next = in_pos_x;
                            cursor_row_next = in_pos_y;
                            state_next      = S_DONE;
                        end
                        CMD_DRAW_CHAR:
                        begin
                            halt_next = halt_eff;
                            code_next = in_char;
                            c_next    = 3'd0;
                            dx_next   = 3'd0;
                            px_next   = cursor_col_reg;
                            if (halt_eff || (in_char == 8'h00))
                            begin
                                state_next = S_DONE;
                            end
                            else if (scale_reg == 3'd0)
                            begin
                                state_next = S_ADV;
                            end
                            else
                            begin
                                state_next = S_COL;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        CMD_READ_BYTE:
                        begin
                            in_range_next = (32'(in_bidx) < STORE_SIZE);
                            state_next    = S_RDATA;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_RDATA:
            begin
                rdata_next = in_range_reg ? ram_rdata : 8'h00;
                state_next = S_DONE;
            end
            S_COL:
            begin
                colbits_next = glyph_bits;
                if ((32'(px_reg) < SCREEN_WIDTH) && (glyph_bits != 8'h00))
                begin
                    page_next  = '0;
                    state_next = S_PRD;
                end
                else
                begin
                    do_step = 1'b1;
                end
            end
            S_PRD:
            begin
                mask_next = unit_mask;
                addr_next = page_addr;
                if (unit_mask != 8'h00)
                begin
                    state_next = S_PWR;
                end
                else
                begin
                    do_page = 1'b1;
                end
            end
            S_PWR:
            begin
                do_page = 1'b1;
            end
            S_ADV:
            begin
                cursor_col_next = adv_col;
                if ((9'(adv_col) + 9'(adv_step)) > 9'(SCREEN_WIDTH))
                begin
                    halt_next = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {7'd0, halt_reg, cursor_col_reg, rdata_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_page)
        begin
            if (page_reg == PAGE_LAST)
            begin
                do_step = 1'b1;
            end
            else
            begin
                page_next  = page_reg + PAGE_W'(1);
                state_next = S_PRD;
            end
        end

        if (do_step)
        begin
            px_next    = px_reg + 8'd1;
            state_next = S_COL;
            if (dx_reg == scale_reg - 3'd1)
            begin
                dx_next = 3'd0;
                c_next  = c_reg + 3'd1;
                if (c_reg == COL_LAST)
                begin
                    state_next = S_ADV;
                end
            end
            else
            begin
                dx_next = dx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            clr_cnt_reg    <= '0;
            cursor_col_reg <= 8'h00;
            cursor_row_reg <= 8'h00;
            halt_reg       <= 1'b0;
            scale_reg      <= SCALE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            halt_reg       <= halt_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                scale_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg        <= c_next;
        dx_reg       <= dx_next;
        px_reg       <= px_next;
        page_reg     <= page_next;
        colbits_reg  <= colbits_next;
        mask_reg     <= mask_next;
        addr_reg     <= addr_next;
        code_reg     <= code_next;
        in_range_reg <= in_range_next;
        rdata_reg    <= rdata_next;
        out_data_reg <= out_data_next;
    end

endmodule

FILE: src/stfr_checker.sv
// Port-level checker for the text framebuffer renderer, bound to the top level.
// Sees only the top-level ports; depends on nothing else.
module stfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    logic [1:0] pend_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(in_acc) - 2'(out_acc);
        end
    end

    // A result only ever follows an accepted item.
    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (pend_reg != 2'd0))
        else $error("result shown with no item outstanding");

    // At most one item in work plus one result waiting.
    a_two_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == 2'd2) |-> !s_axis_tready)
        else $error("input accepted with two items outstanding");

    // The store is swept after reset, so no item is taken right away.
    a_reset_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_axis_tready)
        else $error("input ready during the reset sweep");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed or dropped");

endmodule

bind scaled_text_framebuffer_renderer stfr_checker u_stfr_checker (.*);

FILE: sim/scaled_text_framebuffer_renderer_test.sv
// Testbench for scaled_text_framebuffer_renderer: directed and random command streams
// checked item by item against a framebuffer and cursor predictor kept in the bench.
// Depends on stfr_pkg and the renderer RTL only.
module scaled_text_framebuffer_renderer_test
    import stfr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 8000;

    typedef struct {
        logic [1:0] command;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] character;
        logic       string_start;
        logic [9:0] byte_index;
    } cmd_item_t;

    typedef struct {
        logic [7:0] read_data;
        logic [7:0] cursor_col;
        logic       string_halted;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_wdata = 3'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = 40'd0;
    logic [1:0]  s_axis_tuser = 2'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    logic [7:0]  frame [STORE_SIZE];
    logic [7:0]  cur_col = 8'd0;
    logic [7:0]  cur_row = 8'd0;
    logic        halted = 1'b0;
    logic [2:0]  scale_now = SCALE_RESET;

    result_t     expected_results [$];
    result_t     want;
    int          errors = 0;
    int          results_seen = 0;
    int          stall_cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;

    logic [7:0]  glyph_codes [20] = '{8'd32, 8'd46, 8'd58, 8'd48, 8'd49, 8'd50, 8'd51,
                                      8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd65,
                                      8'd68, 8'd76, 8'd82, 8'd83, 8'd84, 8'd86};

    scaled_text_framebuffer_renderer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        foreach (frame[i])
            frame[i] = 8'h00;
    end

    // Glyph columns listed from column 0 in the top byte down to column 4.
    function automatic logic [7:0] font_bits(input logic [7:0] code, input int c);
        logic [39:0] g;
        case (code)
            8'd46:   g = 40'h00_60_60_00_00;
            8'd58:   g = 40'h00_36_36_00_00;
            8'd48:   g = 40'h3E_51_49_45_3E;
            8'd49:   g = 40'h00_42_7F_40_00;
            8'd50:   g = 40'h42_61_51_49_46;
            8'd51:   g = 40'h21_41_45_4B_31;
            8'd52:   g = 40'h18_14_12_7F_10;
            8'd53:   g = 40'h27_45_45_45_39;
            8'd54:   g = 40'h3C_4A_49_49_30;
            8'd55:   g = 40'h01_71_09_05_03;
            8'd56:   g = 40'h36_49_49_49_36;
            8'd57:   g = 40'h06_49_49_29_1E;
            8'd65:   g = 40'h7E_11_11_11_7E;
            8'd68:   g = 40'h7F_41_41_22_1C;
            8'd76:   g = 40'h7F_40_40_40_40;
            8'd82:   g = 40'h7F_09_19_29_46;
            8'd83:   g = 40'h46_49_49_49_31;
            8'd84:   g = 40'h01_01_7F_01_01;
            8'd86:   g = 40'h1F_20_40_20_1F;
            default: g = 40'h0;
        endcase
        return g[39-8*c -: 8];
    endfunction

    function automatic result_t render_item(input cmd_item_t it);
        result_t    res;
        int         step;
        int         sc;
        int         px;
        int         py;
        logic [7:0] bits;
        res.read_data = 8'h00;
        sc = int'(scale_now);
        case (it.command)
            CMD_SET_CURSOR:
            begin
                cur_col = it.pos_x;
                cur_row = it.pos_y;
            end
            CMD_DRAW_CHAR:
            begin
                if (it.string_start)
                    halted = 1'b0;
                if (!halted && it.character != 8'd0)
                begin
                    step = CELL_STEP * sc;
                    for (int c = 0; c < GLYPH_COLS; c++)
                    begin
                        bits = font_bits(it.character, c);
                        for (int r = 0; r < GLYPH_ROWS; r++)
                            if (bits[r])
                                for (int dx = 0; dx < sc; dx++)
                                    for (int dy = 0; dy < sc; dy++)
                                    begin
                                        px = (int'(cur_col) + c * sc + dx) & 255;
                                        py = (int'(cur_row) + r * sc + dy) & 255;
                                        if (px < SCREEN_WIDTH && py < SCREEN_HEIGHT)
                                            frame[px + (py / 8) * SCREEN_WIDTH][py % 8] = 1'b1;
                                    end
                    end
                    cur_col = 8'(int'(cur_col) + step);
                    if (int'(cur_col) + step > SCREEN_WIDTH)
                        halted = 1'b1;
                end
            end
            CMD_CLEAR:
                foreach (frame[i])
                    frame[i] = 8'h00;
            default:
                if (int'(it.byte_index) < STORE_SIZE)
                    res.read_data = frame[it.byte_index];
        endcase
        res.cursor_col = cur_col;
        res.string_halted = halted;
        return res;
    endfunction

    function automatic cmd_item_t random_fill();
        cmd_item_t it;
        it.command = 2'($urandom_range(3));
        it.pos_x = 8'($urandom_range(255));
        it.pos_y = 8'($urandom_range(255));
        it.character = 8'($urandom_range(255));
        it.string_start = 1'($urandom_range(1));
        it.byte_index = 10'($urandom_range(1023));
        return it;
    endfunction

    function automatic cmd_item_t make_set(input int x, input int y);
        cmd_item_t it;
        it = random_fill();
        it.command = CMD_SET_CURSOR;
        it.pos_x = 8'(x);
        it.pos_y = 8'(y);
        return it;
    endfunction

    function automatic cmd_item_t make_draw(input int code, input logic start);
        cmd_item_t it;
        it = random_fill();
        it.command = CMD_DRAW_CHAR;
        it.character = 8'(code);
        it.string_start = start;
        return it;
    endfunction

    function automatic cmd_item_t make_read(input int idx);
        cmd_item_t it;
        it = random_fill();
        it.command = CMD_READ_BYTE;
        it.byte_index = 10'(idx);
        return it;
    endfunction

    function automatic cmd_item_t make_clear();
        cmd_item_t it;
        it = random_fill();
        it.command = CMD_CLEAR;
        return it;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Called at a rising edge; valid is left high so a following item can go back to back.
    task automatic send_item(input cmd_item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.command;
        s_axis_tdata <= {5'd0, it.byte_index, it.string_start, it.character,
                         it.pos_y, it.pos_x};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(render_item(it));
    endtask

    task automatic write_scale(input logic [2:0] value);
        s_axis_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        scale_now = value;
    endtask

    task automatic test_directed();
        send_item(make_read(0));
        send_item(make_read(1023));
        send_item(make_set(0, 0));
        send_item(make_draw(48, 1'b1));
        send_item(make_draw(65, 1'b0));
        send_item(make_read(2));
        send_item(make_read(SCREEN_WIDTH + 14));
        send_item(make_draw(0, 1'b0));
        send_item(make_draw(200, 1'b1));
        send_item(make_draw(87, 1'b0));
        send_item(make_draw(1, 1'b0));
        send_item(make_set(116, 250));
        send_item(make_draw(76, 1'b1));
        send_item(make_draw(84, 1'b0));
        send_item(make_draw(0, 1'b1));
        send_item(make_read(116));
        send_item(make_set(255, 255));
        send_item(make_draw(82, 1'b1));
        send_item(make_read(5));
        send_item(make_draw(255, 1'b0));
        send_item(make_clear());
        send_item(make_read(2));
    endtask

    task automatic test_scale_extremes();
        write_scale(3'd0);
        send_item(make_set(10, 10));
        send_item(make_draw(56, 1'b1));
        send_item(make_read(SCREEN_WIDTH + 10));
        write_scale(3'd7);
        send_item(make_set(0, 0));
        send_item(make_draw(65, 1'b1));
        send_item(make_draw(86, 1'b0));
        send_item(make_draw(53, 1'b0));
        send_item(make_draw(52, 1'b0));
        send_item(make_read(3 * SCREEN_WIDTH + 50));
    endtask

    task automatic run_strings(input int n_items);
        int        sent;
        int        r;
        int        len;
        int        code;
        int        page;
        cmd_item_t it;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(99);
            if (r < 10)
            begin
                it = random_fill();
                if (it.command == CMD_CLEAR && $urandom_range(3) != 0)
                    it.command = CMD_READ_BYTE;
                send_item(it);
                sent++;
            end
            else if (r < 30)
            begin
                if ($urandom_range(2) == 0)
                    send_item(make_read($urandom_range(1023)));
                else
                begin
                    page = ((int'(cur_row) >> 3) + $urandom_range(3)) % PAGE_COUNT;
                    send_item(make_read(page * SCREEN_WIDTH
                                        + ((int'(cur_col) - $urandom_range(1, 30)) & 127)));
                end
                sent++;
            end
            else
            begin
                send_item(make_set(($urandom_range(3) == 0) ? $urandom_range(255)
                                                             : $urandom_range(100),
                                   ($urandom_range(4) == 0) ? $urandom_range(255)
                                                             : $urandom_range(60)));
                sent++;
                len = $urandom_range(1, 7);
                for (int i = 0; i < len; i++)
                begin
                    code = ($urandom_range(4) != 0) ? int'(glyph_codes[$urandom_range(19)])
                                                    : $urandom_range(255);
                    send_item(make_draw(code, (i == 0) || ($urandom_range(19) == 0)));
                    sent++;
                end
                if ($urandom_range(1) == 1)
                begin
                    send_item(make_draw(0, 1'b0));
                    sent++;
                end
            end
        end
    endtask

    task automatic test_random();
        logic [2:0] scale_order [4];
        scale_order = '{3'd1, 3'd4, 3'd2, 3'd3};
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 60 : 0;
            rx_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 8 : 0;
            for (int k = 0; k < 4; k++)
            begin
                write_scale(scale_order[k]);
                run_strings(155);
            end
        end
    endtask

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_error($sformatf("result %0d with no item pending: %h",
                                       results_seen, m_axis_tdata));
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata[7:0] !== want.read_data)
                    report_error($sformatf("result %0d read_data %h, expected %h",
                                           results_seen, m_axis_tdata[7:0], want.read_data));
                if (m_axis_tdata[15:8] !== want.cursor_col)
                    report_error($sformatf("result %0d cursor_col %0d, expected %0d",
                                           results_seen, m_axis_tdata[15:8], want.cursor_col));
                if (m_axis_tdata[16] !== want.string_halted)
                    report_error($sformatf("result %0d string_halted %b, expected %b",
                                           results_seen, m_axis_tdata[16], want.string_halted));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("scaled_text_framebuffer_renderer verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_scale_extremes();
        test_random();
        s_axis_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("scaled_text_framebuffer_renderer verification clean");
        else
            $display("scaled_text_framebuffer_renderer verification failed");
        $finish;
    end

endmodule

FILE: sim.f
src/stfr_pkg.sv
src/stfr_ram.sv
src/stfr_mask.sv
src/scaled_text_framebuffer_renderer.sv
src/stfr_checker.sv
sim/scaled_text_framebuffer_renderer_test.sv
